// ----- design/huffman_table_encoder_defines.svh -----
// assertion macros used by the huffman table encoder checker
`ifndef HUFFMAN_TABLE_ENCODER_DEFINES_SVH
`define HUFFMAN_TABLE_ENCODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hte_pkg.sv -----
// types and constants shared by the huffman table encoder modules
`timescale 1ns / 1ps

package hte_pkg;

    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int ENTRY_W = LEN_W + CODE_W;
    localparam int PEND_W  = 7;
    localparam int CNT_W   = 3;
    localparam int ACC_W   = PEND_W + CODE_W;
    localparam int TOTAL_W = 6;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_ENCODE = 2'd1;
    localparam logic [1:0] ACT_FLUSH  = 2'd2;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_COUNT = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } hte_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       is_last;
    } hte_result_t;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic emit;
        logic flush_pad;
        logic flush_cnt;
    } hte_cmd_t;

    typedef struct packed {
        logic enc_error;
        logic enc_has_byte;
        logic more_bytes;
    } hte_status_t;

endpackage

// ----- design/huffman_table_encoder.sv -----
// top level of the huffman table encoder
`timescale 1ns / 1ps

// Huffman encoder with a loadable code table. A transaction is taken when start
// is high and busy is low; busy stays low after a table load, so loads go one per
// cycle. An encode keeps busy high in the lookup state when it gives no byte or an
// error, and also in the emit state when it releases n bytes (n up to 4), one byte
// per cycle. A flush keeps busy high in the pad state and then the count state.
// The lookup state covers the registered read of the code table memory, and all
// results come from the single result register. Every result stands on the result
// port for exactly one cycle with result_valid high and cannot be held back, so
// the receiver must take it in that cycle. Results appear in order, the last of
// each transaction marked by is_last.
module huffman_table_encoder
    import hte_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int TABLE_DEPTH  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  hte_item_t   item,
    output logic        result_valid,
    output hte_result_t result
);

    hte_cmd_t    cmd;
    hte_status_t status;

    hte_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (item.action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    hte_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- design/hte_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module hte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/hte_ctrl.sv -----
// controller state machine of the huffman table encoder
`timescale 1ns / 1ps

module hte_ctrl
    import hte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  action,
    input  hte_status_t status,
    output hte_cmd_t    cmd,
    output logic        busy
);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_LOOKUP    = 5'b00010,
        ST_EMIT      = 5'b00100,
        ST_FLUSH_PAD = 5'b01000,
        ST_FLUSH_CNT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_ENCODE)
                begin
                    state_next = ST_LOOKUP;
                end
                else if (accept && action == ACT_FLUSH)
                begin
                    state_next = ST_FLUSH_PAD;
                end
            end
            ST_LOOKUP:
            begin
                if (!status.enc_error && status.enc_has_byte)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!status.more_bytes)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH_PAD:
            begin
                state_next = ST_FLUSH_CNT;
            end
            ST_FLUSH_CNT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.accept    = accept;
    assign cmd.lookup    = (state_reg == ST_LOOKUP);
    assign cmd.emit      = (state_reg == ST_EMIT);
    assign cmd.flush_pad = (state_reg == ST_FLUSH_PAD);
    assign cmd.flush_cnt = (state_reg == ST_FLUSH_CNT);

endmodule

// ----- design/hte_datapath.sv -----
// datapath of the huffman table encoder: code table, bit buffer, result register
`timescale 1ns / 1ps

module hte_datapath
    import hte_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int TABLE_DEPTH  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  hte_item_t   item,
    input  hte_cmd_t    cmd,
    output hte_status_t status,
    output logic        result_valid,
    output hte_result_t result
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [PEND_W-1:0]      pending_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   err_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    hte_result_t            result_reg;
    hte_result_t            result_next;

    logic                   in_range;
    logic [IDX_W-1:0]       idx;
    logic                   load_we;
    logic                   lookup_re;
    logic [LEN_W-1:0]       load_len;
    logic [CODE_W:0]        load_mask;
    logic [ENTRY_W-1:0]     load_entry;
    logic [ENTRY_W-1:0]     entry;
    logic [LEN_W-1:0]       ent_len;
    logic [ACC_W-1:0]       acc_calc;
    logic [TOTAL_W-1:0]     total_calc;
    logic [TOTAL_W-1:0]     emit_total;
    logic [7:0]             emit_byte;
    logic [7:0]             tail_mask;
    logic [14:0]            pad_wide;

    assign in_range  = ({1'b0, item.symbol} < 9'(TABLE_DEPTH));
    assign idx       = item.symbol[IDX_W-1:0];
    assign load_we   = cmd.accept && (item.action == ACT_LOAD) && in_range;
    assign lookup_re = cmd.accept && (item.action == ACT_ENCODE) && in_range;

    // saturate the length and drop code bits above it
    assign load_len   = (item.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                              : item.code_length;
    assign load_mask  = (33'd1 << load_len) - 33'd1;
    assign load_entry = {load_len, item.code_bits & load_mask[CODE_W-1:0]};

    hte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (idx),
        .wdata (load_entry),
        .re    (lookup_re),
        .raddr (idx),
        .rdata (entry)
    );

    // append the looked-up code to the buffered bits
    assign ent_len    = entry[ENTRY_W-1:CODE_W];
    assign acc_calc   = (ACC_W'(pending_reg) << ent_len) | ACC_W'(entry[CODE_W-1:0]);
    assign total_calc = TOTAL_W'(count_reg) + ent_len;

    // one byte a cycle, taken from the top of the valid bits
    assign emit_total = total_reg - TOTAL_W'(8);
    assign emit_byte  = 8'(acc_reg >> emit_total);
    assign tail_mask  = ~(8'hFF << emit_total[CNT_W-1:0]);

    assign pad_wide = 15'(pending_reg) << (4'd8 - {1'b0, count_reg});

    assign status.enc_error    = err_reg;
    assign status.enc_has_byte = (total_calc >= TOTAL_W'(8));
    assign status.more_bytes   = (emit_total >= TOTAL_W'(8));

    always_comb
    begin
        result_valid_next = 1'b0;
        result_next       = result_reg;
        if (cmd.lookup && err_reg)
        begin
            result_valid_next    = 1'b1;
            result_next.out_byte = 8'd0;
            result_next.out_kind = KIND_ERROR;
            result_next.is_last  = 1'b1;
        end
        else if (cmd.emit)
        begin
            result_valid_next    = 1'b1;
            result_next.out_byte = emit_byte;
            result_next.out_kind = KIND_DATA;
            result_next.is_last  = !status.more_bytes;
        end
        else if (cmd.flush_pad)
        begin
            result_valid_next    = 1'b1;
            result_next.out_byte = pad_wide[7:0];
            result_next.out_kind = KIND_DATA;
            result_next.is_last  = 1'b0;
        end
        else if (cmd.flush_cnt)
        begin
            result_valid_next    = 1'b1;
            result_next.out_byte = 8'(count_reg);
            result_next.out_kind = KIND_COUNT;
            result_next.is_last  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            pending_reg      <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (load_we)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (cmd.lookup && !err_reg && !status.enc_has_byte)
            begin
                pending_reg <= acc_calc[PEND_W-1:0];
                count_reg   <= total_calc[CNT_W-1:0];
            end
            else if (cmd.emit && !status.more_bytes)
            begin
                pending_reg <= acc_reg[PEND_W-1:0] & tail_mask[PEND_W-1:0];
                count_reg   <= emit_total[CNT_W-1:0];
            end
            else if (cmd.flush_cnt)
            begin
                pending_reg <= '0;
                count_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (cmd.accept)
        begin
            err_reg <= !(in_range && valid_reg[idx]);
        end
        if (cmd.lookup && !err_reg)
        begin
            acc_reg   <= acc_calc;
            total_reg <= total_calc;
        end
        else if (cmd.emit)
        begin
            total_reg <= emit_total;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- design/hte_checker.sv -----
// port-level checker for the huffman table encoder, with its bind
`timescale 1ns / 1ps
`include "huffman_table_encoder_defines.svh"

module hte_checker
    import hte_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input hte_item_t   item,
    input logic        result_valid,
    input hte_result_t result
);

    // a flush always occupies the block in the following cycle
    `HTE_ASSERT_NEXT(a_flush_busy, clk, rst_n, start && !busy && item.action == ACT_FLUSH, busy, "flush transaction did not raise busy")

    // a table load neither stalls nor produces a result
    `HTE_ASSERT_NEXT(a_load_silent, clk, rst_n, start && !busy && item.action == ACT_LOAD, !busy && !result_valid, "table load stalled or gave a result")

    // the trailing count closes a flush and is at most seven
    `HTE_ASSERT_NOW(a_count_form, clk, rst_n, result_valid && result.out_kind == KIND_COUNT, result.is_last && result.out_byte < 8'd8, "bad trailing bit count result")

    // the count directly follows the padded data byte
    `HTE_ASSERT_NOW(a_count_after_pad, clk, rst_n, result_valid && result.out_kind == KIND_COUNT, $past(result_valid) && $past(result.out_kind) == KIND_DATA && !$past(result.is_last), "count not preceded by padded byte")

    // an error result is a lone zero
    `HTE_ASSERT_NOW(a_error_form, clk, rst_n, result_valid && result.out_kind == KIND_ERROR, result.is_last && result.out_byte == 8'd0, "bad unknown symbol result")

endmodule

bind huffman_table_encoder hte_checker u_checker (.*);
